// File: hdl/mm64_pkg.sv
// Shared types, constants and helper functions for the MurmurHash64A stream hasher.
package mm64_pkg;

  // Mixing multiplier and shift of the hash algorithm.
  localparam logic [63:0] MIX_MULT    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MULT_LO = MIX_MULT[31:0];
  localparam logic [31:0] MIX_MULT_HI = MIX_MULT[63:32];
  localparam int unsigned MIX_SHIFT   = 47;

  // Number of bytes in one full block.
  localparam logic [3:0] FULL_COUNT = 4'd8;

  // Sequencer states of the hash core.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_K1,
    ST_K2,
    ST_H,
    ST_FIN
  } seq_state_e;

  // Partial-product phases of the shared multiplier.
  typedef enum logic [1:0] {
    PH_LL,
    PH_LH,
    PH_HL
  } mul_phase_e;

  // Xor a word with itself shifted right by the mixing shift.
  function automatic logic [63:0] shift_xor(input logic [63:0] x);
    shift_xor = x ^ (x >> MIX_SHIFT);
  endfunction

  // Keep only the low count bytes of a word (count 0 to 7).
  function automatic logic [63:0] byte_mask(input logic [63:0] x, input logic [3:0] count);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < count) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    byte_mask = x & m;
  endfunction

endpackage

// File: hdl/mm64_mul.sv
// Shared iterative multiplier: low 64 bits of operand times the mixing constant.
module mm64_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] operand_i,
  output logic        busy_o,
  output logic [63:0] product_o
);

  logic                 busy_q, busy_d;
  mm64_pkg::mul_phase_e phase_q, phase_d;
  logic [63:0]          a_q, a_d;
  logic [63:0]          acc_q, acc_d;
  logic [31:0]          x_op, y_op;
  logic [63:0]          pp;

  // Pick one 32 by 32 partial product per cycle.
  always_comb begin
    x_op = a_q[31:0];
    y_op = mm64_pkg::MIX_MULT_LO;
    case (phase_q)
      mm64_pkg::PH_LL: begin
        x_op = a_q[31:0];
        y_op = mm64_pkg::MIX_MULT_LO;
      end
      mm64_pkg::PH_LH: begin
        x_op = a_q[31:0];
        y_op = mm64_pkg::MIX_MULT_HI;
      end
      mm64_pkg::PH_HL: begin
        x_op = a_q[63:32];
        y_op = mm64_pkg::MIX_MULT_LO;
      end
      default: begin
        x_op = a_q[31:0];
        y_op = mm64_pkg::MIX_MULT_LO;
      end
    endcase
  end

  assign pp = 64'(x_op) * 64'(y_op);

  // Accumulate the partial products; the high-by-high term falls off the word.
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    a_d     = a_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = mm64_pkg::PH_LL;
      a_d     = operand_i;
    end else if (busy_q) begin
      case (phase_q)
        mm64_pkg::PH_LL: begin
          acc_d   = pp;
          phase_d = mm64_pkg::PH_LH;
        end
        mm64_pkg::PH_LH: begin
          acc_d   = acc_q + {pp[31:0], 32'd0};
          phase_d = mm64_pkg::PH_HL;
        end
        mm64_pkg::PH_HL: begin
          acc_d   = acc_q + {pp[31:0], 32'd0};
          busy_d  = 1'b0;
        end
        default: begin
          busy_d  = 1'b0;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= mm64_pkg::PH_LL;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  // Operand and accumulator.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign busy_o    = busy_q;
  assign product_o = acc_q;

endmodule

// File: hdl/murmur64a_stream_hash_core.sv
// Top level of the MurmurHash64A stream hasher: sequencer around the shared multiplier.
// Each multiply by the mixing constant runs as a start step and then three partial products.
// An item needs one multiply for the length on a first block, three for a full block,
// one for a partial block and one more on a last block.
// A result waits in an output register while the next beat is taken; a new hash waits for it.
// Reset clears the seed to zero, the message state and the output valid.
module murmur64a_stream_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Seed write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_hash_seed_i,
  // Input block channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_block_i,
  input  logic [31:0] message_length_i,
  // Hash result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  mm64_pkg::seq_state_e state_q, state_d;
  logic [63:0] seed_q;
  logic        in_msg_q, in_msg_d;
  logic [63:0] run_q, run_d;
  logic [63:0] h_q, h_d;
  logic [63:0] data_q;
  logic [3:0]  count_q;
  logic        last_q;
  logic        out_valid_q;
  logic [63:0] hash_q;

  logic        in_accept;
  logic        out_load;
  logic        mul_start;
  logic [63:0] mul_a;
  logic        mul_busy;
  logic [63:0] mul_p;
  logic        disp;
  logic [63:0] disp_h;
  logic [3:0]  in_count;
  logic [63:0] cur_data;
  logic [3:0]  cur_count;
  logic        cur_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != mm64_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // Counts above eight act as a full block.
  assign in_count = byte_count_i[3] ? mm64_pkg::FULL_COUNT : byte_count_i;

  // During the accepting cycle the beat comes straight from the ports.
  assign cur_data  = (state_q == mm64_pkg::ST_IDLE) ? block_data_i : data_q;
  assign cur_count = (state_q == mm64_pkg::ST_IDLE) ? in_count : count_q;
  assign cur_last  = (state_q == mm64_pkg::ST_IDLE) ? last_block_i : last_q;

  mm64_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .operand_i(mul_a),
    .busy_o   (mul_busy),
    .product_o(mul_p)
  );

  // Sequencer: next state and multiplier requests.
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    h_d       = h_q;
    run_d     = run_q;
    in_msg_d  = in_msg_q;
    out_load  = 1'b0;
    disp      = 1'b0;
    disp_h    = '0;

    case (state_q)
      mm64_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_msg_q) begin
            disp   = 1'b1;
            disp_h = run_q;
          end else begin
            mul_start = 1'b1;
            mul_a     = {32'd0, message_length_i};
            state_d   = mm64_pkg::ST_LEN;
          end
        end
      end
      mm64_pkg::ST_LEN: begin
        if (!mul_busy) begin
          disp   = 1'b1;
          disp_h = seed_q ^ mul_p;
        end
      end
      mm64_pkg::ST_K1: begin
        if (!mul_busy) begin
          mul_start = 1'b1;
          mul_a     = mm64_pkg::shift_xor(mul_p);
          state_d   = mm64_pkg::ST_K2;
        end
      end
      mm64_pkg::ST_K2: begin
        if (!mul_busy) begin
          mul_start = 1'b1;
          mul_a     = h_q ^ mul_p;
          state_d   = mm64_pkg::ST_H;
        end
      end
      mm64_pkg::ST_H: begin
        if (!mul_busy) begin
          if (last_q) begin
            mul_start = 1'b1;
            mul_a     = mm64_pkg::shift_xor(mul_p);
            state_d   = mm64_pkg::ST_FIN;
          end else begin
            run_d    = mul_p;
            in_msg_d = 1'b1;
            state_d  = mm64_pkg::ST_IDLE;
          end
        end
      end
      mm64_pkg::ST_FIN: begin
        if (!mul_busy && (!out_valid_q || !out_stall_i)) begin
          out_load = 1'b1;
          in_msg_d = 1'b0;
          state_d  = mm64_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mm64_pkg::ST_IDLE;
      end
    endcase

    // Choose the block work once the starting hash is known.
    if (disp) begin
      h_d = disp_h;
      if (cur_count == mm64_pkg::FULL_COUNT) begin
        mul_start = 1'b1;
        mul_a     = cur_data;
        state_d   = mm64_pkg::ST_K1;
      end else if (cur_count != 4'd0) begin
        mul_start = 1'b1;
        mul_a     = disp_h ^ mm64_pkg::byte_mask(cur_data, cur_count);
        state_d   = mm64_pkg::ST_H;
      end else if (cur_last) begin
        mul_start = 1'b1;
        mul_a     = mm64_pkg::shift_xor(disp_h);
        state_d   = mm64_pkg::ST_FIN;
      end else begin
        run_d    = disp_h;
        in_msg_d = 1'b1;
        state_d  = mm64_pkg::ST_IDLE;
      end
    end
  end

  // Control state, seed and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mm64_pkg::ST_IDLE;
      in_msg_q    <= 1'b0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_msg_q <= in_msg_d;
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_hash_seed_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Beat capture, working hash and result register.
  always_ff @(posedge clk_i) begin
    run_q <= run_d;
    h_q   <= h_d;
    if (in_accept) begin
      data_q  <= block_data_i;
      count_q <= in_count;
      last_q  <= last_block_i;
    end
    if (out_load) begin
      hash_q <= mm64_pkg::shift_xor(mul_p);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule
